FILE: rtl/core/txs_pkg.sv
// Shared widths, codes, types and coordinate helpers for the texture sampler.
`default_nettype none
package txs_pkg;

    localparam int MAX_TEXELS = 65536;
    localparam int MAX_DIM    = 1024;
    localparam int CHAN_W     = 16;
    localparam int N_CHAN     = 4;
    localparam int TEXEL_W    = N_CHAN * CHAN_W;
    localparam int ADDR_W     = $clog2(MAX_TEXELS);
    localparam int WIDX_W     = 16;
    localparam int CRD_W      = $clog2(MAX_DIM);
    localparam int ESZ_W      = CRD_W + 1;
    localparam int SIZE_W     = 11;
    localparam int UV_W       = 20;
    localparam int FRAC_W     = 16;
    localparam int INT_W      = UV_W - FRAC_W;
    localparam int TX_W       = ESZ_W + INT_W;
    localparam int PROD_W     = UV_W + ESZ_W + 1;
    localparam int LIN_W      = CRD_W + ESZ_W + 1;
    localparam int N_TAPS     = 5;
    localparam int TAP_W      = $clog2(N_TAPS);
    localparam int ACC_W      = CHAN_W + $clog2(N_TAPS);
    localparam int DIV5_SHIFT = ACC_W + 2;
    localparam logic [ACC_W-1:0] DIV5_MUL = ACC_W'((1 << DIV5_SHIFT) / N_TAPS + 1);
    localparam logic [PROD_W-1:0] FRAC_MASK = PROD_W'((1 << FRAC_W) - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic [1:0] FLT_NEAREST = 2'd0;
    localparam logic [1:0] FLT_CROSS   = 2'd1;
    localparam logic       WRAP_CLAMP  = 1'b0;
    localparam logic       WRAP_REPEAT = 1'b1;
    localparam logic       OP_WRITE    = 1'b0;
    localparam logic       OP_LOOKUP   = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [UV_W-1:0]   coord_u;
        logic signed [UV_W-1:0]   coord_v;
        logic [WIDX_W-1:0]        write_index;
        logic [CHAN_W-1:0]        red;
        logic [CHAN_W-1:0]        green;
        logic [CHAN_W-1:0]        blue;
        logic [CHAN_W-1:0]        alpha;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_px;

    typedef struct packed {
        logic             store;
        logic             load;
        logic             scale;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic out_free;
        logic nearest;
        logic black;
    } t_dp_sts;

    function automatic logic [ESZ_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val);
        logic [ESZ_W-1:0] res;
        if (reg_val == '0) begin
            res = ESZ_W'(1);
        end else if (reg_val > SIZE_W'(MAX_DIM)) begin
            res = ESZ_W'(MAX_DIM);
        end else begin
            res = ESZ_W'(reg_val);
        end
        return res;
    endfunction

    // coordinate times size, truncated toward zero
    function automatic logic signed [TX_W-1:0] scale_coord(input logic signed [UV_W-1:0] c,
                                                           input logic [ESZ_W-1:0] sz);
        logic signed [PROD_W-1:0] p;
        p = c * $signed({1'b0, sz});
        if (p < 0) begin
            p = p + FRAC_MASK;
        end
        return p[FRAC_W +: TX_W];
    endfunction

    function automatic logic signed [1:0] tap_dx(input logic [TAP_W-1:0] k);
        logic signed [1:0] d;
        case (k)
            3'd1:    d = 2'sd1;
            3'd2:    d = -2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] tap_dy(input logic [TAP_W-1:0] k);
        logic signed [1:0] d;
        case (k)
            3'd3:    d = 2'sd1;
            3'd4:    d = -2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

    // clamp to [0, size-1] or true modulo; |c| stays below 2^INT_W times size
    function automatic logic [CRD_W-1:0] fix_coord(input logic signed [TX_W-1:0] c,
                                                   input logic [ESZ_W-1:0] sz,
                                                   input logic wrap);
        logic [TX_W-1:0]  mag;
        logic [TX_W-1:0]  szx;
        logic [TX_W-1:0]  step;
        logic [CRD_W-1:0] res;
        int               i;
        szx = TX_W'(sz);
        if (wrap == WRAP_CLAMP) begin
            if (c[TX_W-1]) begin
                res = '0;
            end else if (TX_W'(c) > szx - TX_W'(1)) begin
                res = CRD_W'(szx - TX_W'(1));
            end else begin
                res = CRD_W'(c);
            end
        end else begin
            mag = c[TX_W-1] ? TX_W'(-c) : TX_W'(c);
            for (i = INT_W - 1; i >= 0; i--) begin
                step = szx << i;
                if (mag >= step) begin
                    mag = mag - step;
                end
            end
            if (c[TX_W-1] && (mag != '0)) begin
                mag = szx - mag;
            end
            res = CRD_W'(mag);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/txs_if.sv
// Stream interfaces for lookup/write beats and sampled texel beats.
`default_nettype none
interface txs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [txs_pkg::UV_W-1:0]   coord_u;
    logic signed [txs_pkg::UV_W-1:0]   coord_v;
    logic [txs_pkg::WIDX_W-1:0]        write_index;
    logic [txs_pkg::CHAN_W-1:0]        in_red;
    logic [txs_pkg::CHAN_W-1:0]        in_green;
    logic [txs_pkg::CHAN_W-1:0]        in_blue;
    logic [txs_pkg::CHAN_W-1:0]        in_alpha;

    modport source (output valid, op, coord_u, coord_v, write_index,
                    in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, op, coord_u, coord_v, write_index,
                    in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface txs_out_if;
    logic                       valid;
    logic                       ready;
    logic [txs_pkg::CHAN_W-1:0] out_red;
    logic [txs_pkg::CHAN_W-1:0] out_green;
    logic [txs_pkg::CHAN_W-1:0] out_blue;
    logic [txs_pkg::CHAN_W-1:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/txs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module txs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/txs_dp.sv
// Sampler datapath: config registers, coordinate pipeline, texel store, accumulate, result.
`default_nettype none
module txs_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire txs_pkg::t_dp_cmd                  i_cmd,
    output txs_pkg::t_dp_sts                       o_sts,
    input  wire txs_pkg::t_in_beat                 i_beat,
    input  wire logic                              i_cfg_we,
    input  wire logic [txs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [txs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output txs_pkg::t_px                           o_px,
    output logic                                   o_valid,
    input  wire logic                              i_ready
);
    logic [1:0]                         r_filter;
    logic                               r_wrap;
    logic [txs_pkg::SIZE_W-1:0]         r_width;
    logic [txs_pkg::SIZE_W-1:0]         r_height;

    logic signed [txs_pkg::UV_W-1:0]    r_u, r_v;
    logic signed [txs_pkg::TX_W-1:0]    r_tx, r_ty;
    logic [txs_pkg::CRD_W-1:0]          r_x, r_y;
    logic [txs_pkg::ADDR_W-1:0]         r_addr;
    logic                               r_fv, r_av, r_rv;
    logic [txs_pkg::ACC_W-1:0]          r_acc [txs_pkg::N_CHAN];
    logic                               r_ov;
    txs_pkg::t_px                       r_px;

    logic [txs_pkg::ESZ_W-1:0]          w_eff, h_eff;
    logic signed [txs_pkg::TX_W-1:0]    cx, cy;
    logic [txs_pkg::LIN_W-1:0]          lin;
    logic [txs_pkg::ADDR_W-1:0]         ram_addr;
    logic [txs_pkg::TEXEL_W-1:0]        ram_wdata, ram_rdata;
    logic                               out_free;
    logic                               nearest, black;
    txs_pkg::t_px                       n_px;

    function automatic logic [txs_pkg::CHAN_W-1:0] div5(input logic [txs_pkg::ACC_W-1:0] s);
        logic [2*txs_pkg::ACC_W-1:0] p;
        p = s * txs_pkg::DIV5_MUL;
        return p[txs_pkg::DIV5_SHIFT +: txs_pkg::CHAN_W];
    endfunction

    assign w_eff    = txs_pkg::eff_size(r_width);
    assign h_eff    = txs_pkg::eff_size(r_height);
    assign nearest  = (r_filter == txs_pkg::FLT_NEAREST);
    assign black    = !nearest && (r_filter != txs_pkg::FLT_CROSS);
    assign out_free = !r_ov || i_ready;

    assign cx  = r_tx + txs_pkg::TX_W'(txs_pkg::tap_dx(i_cmd.tap));
    assign cy  = r_ty + txs_pkg::TX_W'(txs_pkg::tap_dy(i_cmd.tap));
    assign lin = txs_pkg::LIN_W'(r_y * w_eff) + txs_pkg::LIN_W'(r_x);

    assign ram_addr  = i_cmd.store ? txs_pkg::ADDR_W'(i_beat.write_index) : r_addr;
    assign ram_wdata = {i_beat.alpha, i_beat.blue, i_beat.green, i_beat.red};

    txs_ram #(
        .WIDTH (txs_pkg::TEXEL_W),
        .DEPTH (txs_pkg::MAX_TEXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (black) begin
            n_px.red   = '0;
            n_px.green = '0;
            n_px.blue  = '0;
            n_px.alpha = '1;
        end else if (nearest) begin
            n_px.red   = r_acc[0][txs_pkg::CHAN_W-1:0];
            n_px.green = r_acc[1][txs_pkg::CHAN_W-1:0];
            n_px.blue  = r_acc[2][txs_pkg::CHAN_W-1:0];
            n_px.alpha = r_acc[3][txs_pkg::CHAN_W-1:0];
        end else begin
            n_px.red   = div5(r_acc[0]);
            n_px.green = div5(r_acc[1]);
            n_px.blue  = div5(r_acc[2]);
            n_px.alpha = div5(r_acc[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= txs_pkg::FLT_CROSS;
            r_wrap   <= txs_pkg::WRAP_REPEAT;
            r_width  <= txs_pkg::SIZE_W'(1);
            r_height <= txs_pkg::SIZE_W'(1);
            r_fv     <= 1'b0;
            r_av     <= 1'b0;
            r_rv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    txs_pkg::CFG_FILTER: r_filter <= i_cfg_data[1:0];
                    txs_pkg::CFG_WRAP:   r_wrap   <= i_cfg_data[0];
                    txs_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    txs_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_fv <= i_cmd.issue;
            r_av <= r_fv;
            r_rv <= r_av;
            if (i_cmd.finish) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u <= i_beat.coord_u;
            r_v <= i_beat.coord_v;
        end
        if (i_cmd.scale) begin
            r_tx <= txs_pkg::scale_coord(r_u, w_eff);
            r_ty <= txs_pkg::scale_coord(r_v, h_eff);
        end
        if (i_cmd.issue) begin
            r_x <= txs_pkg::fix_coord(cx, w_eff, r_wrap);
            r_y <= txs_pkg::fix_coord(cy, h_eff, r_wrap);
        end
        if (r_fv) begin
            r_addr <= lin[txs_pkg::ADDR_W-1:0];
        end
        for (int c = 0; c < txs_pkg::N_CHAN; c++) begin
            if (i_cmd.scale) begin
                r_acc[c] <= '0;
            end else if (r_rv) begin
                r_acc[c] <= r_acc[c]
                          + txs_pkg::ACC_W'(ram_rdata[c*txs_pkg::CHAN_W +: txs_pkg::CHAN_W]);
            end
        end
        if (i_cmd.finish) begin
            r_px <= n_px;
        end
    end

    assign o_sts.pipe_empty = !r_fv && !r_av && !r_rv;
    assign o_sts.out_free   = out_free;
    assign o_sts.nearest    = nearest;
    assign o_sts.black      = black;
    assign o_px             = r_px;
    assign o_valid          = r_ov;

    // a result beat only appears after a finish command
    a_ov_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(i_cmd.finish))
        else $error("result valid without finish");

    // finish never overwrites a beat that is still waiting
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> out_free)
        else $error("finish while output slot full");

    // store write never collides with a tap read in flight
    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (!r_fv && !r_av && !i_cmd.issue))
        else $error("texel write during tap reads");
endmodule
`default_nettype wire

FILE: rtl/core/txs_ctrl.sv
// Sampler controller: accept, scale, tap issue, drain and result hand-off.
`default_nettype none
module txs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_op,
    input  wire txs_pkg::t_dp_sts  i_sts,
    output logic                   o_ready,
    output txs_pkg::t_dp_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_TAPS,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                      r_state, n_state;
    logic [txs_pkg::TAP_W-1:0]   r_cnt, n_cnt;
    logic [txs_pkg::TAP_W-1:0]   last_tap;
    logic                        fire;

    assign o_ready  = (r_state == S_IDLE);
    assign fire     = o_ready && i_valid;
    assign last_tap = i_sts.nearest ? '0 : txs_pkg::TAP_W'(txs_pkg::N_TAPS - 1);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.tap    = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.store = fire && (i_op == txs_pkg::OP_WRITE);
                o_cmd.load  = fire && (i_op == txs_pkg::OP_LOOKUP);
                if (o_cmd.load) begin
                    n_state = i_sts.black ? S_FINISH : S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_cnt       = '0;
                n_state     = S_TAPS;
            end
            S_TAPS: begin
                o_cmd.issue = 1'b1;
                if (r_cnt == last_tap) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + txs_pkg::TAP_W'(1);
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= txs_pkg::TAP_W'(txs_pkg::N_TAPS - 1))
        else $error("tap count out of range");

    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && i_sts.pipe_empty) |=> (r_state == S_FINISH))
        else $error("drain did not hand off to finish");
endmodule
`default_nettype wire

FILE: rtl/core/texture_sample_wrap_cross_filter_core.sv
// Top level of the texture sampler: wraps controller and datapath onto the stream ports.
//
//   channel   dir  handshake          beat contents
//   i_tex     in   valid/ready        op, coord_u, coord_v, write_index, in_red..in_alpha
//   o_smp     out  valid/ready        out_red, out_green, out_blue, out_alpha
//   i_cfg_*   in   write enable only  register index, data
//
// Write beat: stored in the cycle it is accepted. Lookup: five taps in cross mode, one in
// nearest, none for black; one store port, four-stage fix/address/read/accumulate pipe.
// Synchronous active-low reset; no clearing pass, the store is undefined until written.
// The output register holds a result while the next beat is taken; a lookup that
// finishes while that register is still full waits until o_smp.ready.
`default_nettype none
module texture_sample_wrap_cross_filter_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    txs_in_if.sink                              i_tex,
    txs_out_if.source                           o_smp,
    input  wire logic                           i_cfg_we,
    input  wire logic [txs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [txs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    txs_pkg::t_dp_cmd   cmd;
    txs_pkg::t_dp_sts   sts;
    txs_pkg::t_in_beat  beat;
    txs_pkg::t_px       px;
    logic               rdy;
    logic               ov;

    assign beat.op          = i_tex.op;
    assign beat.coord_u     = i_tex.coord_u;
    assign beat.coord_v     = i_tex.coord_v;
    assign beat.write_index = i_tex.write_index;
    assign beat.red         = i_tex.in_red;
    assign beat.green       = i_tex.in_green;
    assign beat.blue        = i_tex.in_blue;
    assign beat.alpha       = i_tex.in_alpha;
    assign i_tex.ready      = rdy;

    txs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tex.valid),
        .i_op    (i_tex.op),
        .i_sts   (sts),
        .o_ready (rdy),
        .o_cmd   (cmd)
    );

    txs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_beat     (beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_px       (px),
        .o_valid    (ov),
        .i_ready    (o_smp.ready)
    );

    assign o_smp.valid     = ov;
    assign o_smp.out_red   = px.red;
    assign o_smp.out_green = px.green;
    assign o_smp.out_blue  = px.blue;
    assign o_smp.out_alpha = px.alpha;

    // input side opens only with the tap pipe empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rdy |-> sts.pipe_empty)
        else $error("input ready while taps in flight");
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the texture sampler: predicts every sampled texel and checks it.
module testbench;
    import txs_pkg::*;

    localparam logic [1:0] FLT_BLACK      = 2'd2;
    localparam logic [1:0] FLT_BLACK_HI   = 2'd3;
    localparam logic signed [UV_W-1:0] UV_MIN = {1'b1, {(UV_W-1){1'b0}}};
    localparam logic signed [UV_W-1:0] UV_MAX = {1'b0, {(UV_W-1){1'b1}}};
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         PHASE_BEATS    = 100;
    localparam int         RANDOM_PHASES  = 11;

    class texel_scoreboard;
        logic [TEXEL_W-1:0] texels [int];
        logic [1:0]         filter;
        logic               wrap;
        logic [SIZE_W-1:0]  width_reg;
        logic [SIZE_W-1:0]  height_reg;
        t_px                expected_px [$];
        int                 errors;

        function new();
            filter     = FLT_CROSS;
            wrap       = WRAP_REPEAT;
            width_reg  = SIZE_W'(1);
            height_reg = SIZE_W'(1);
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FILTER: filter     = data[1:0];
                CFG_WRAP:   wrap       = data[0];
                CFG_WIDTH:  width_reg  = data;
                CFG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function longint dim(logic [SIZE_W-1:0] r);
            longint s;
            s = longint'(r);
            if (s < 1) s = 1;
            if (s > MAX_DIM) s = MAX_DIM;
            return s;
        endfunction

        function longint texel_span();
            return dim(width_reg) * dim(height_reg);
        endfunction

        function longint fold(longint c, longint sz);
            longint r;
            if (wrap == WRAP_CLAMP) begin
                r = (c < 0) ? 0 : ((c > sz - 1) ? sz - 1 : c);
            end else begin
                r = c % sz;
                if (r < 0) r += sz;
            end
            return r;
        endfunction

        // store addresses read by a lookup, center tap first
        function void tap_addrs(input logic signed [UV_W-1:0] u,
                                input logic signed [UV_W-1:0] v, output int addrs[$]);
            int     dx [5] = '{0, 1, -1, 0, 0};
            int     dy [5] = '{0, 0, 0, 1, -1};
            longint w, h, tx, ty, x, y;
            int     taps;
            w  = dim(width_reg);
            h  = dim(height_reg);
            tx = (longint'(u) * w) / 65536;
            ty = (longint'(v) * h) / 65536;
            taps = (filter == FLT_NEAREST) ? 1 : ((filter == FLT_CROSS) ? N_TAPS : 0);
            addrs.delete();
            for (int k = 0; k < taps; k++) begin
                x = fold(tx + dx[k], w);
                y = fold(ty + dy[k], h);
                addrs.push_back(int'((y * w + x) % MAX_TEXELS));
            end
        endfunction

        function bit has_texel(int a);
            return texels.exists(a);
        endfunction

        function void note_beat(t_in_beat b);
            int                 addrs [$];
            longint             sum [N_CHAN];
            logic [TEXEL_W-1:0] t;
            t_px                px;
            if (b.op == OP_WRITE) begin
                texels[int'(b.write_index)] = {b.alpha, b.blue, b.green, b.red};
                return;
            end
            tap_addrs(b.coord_u, b.coord_v, addrs);
            foreach (sum[c]) sum[c] = 0;
            foreach (addrs[k]) begin
                t = texels[addrs[k]];
                foreach (sum[c]) sum[c] += longint'(t[c*CHAN_W +: CHAN_W]);
            end
            if (filter == FLT_NEAREST || filter == FLT_CROSS) begin
                px.red   = CHAN_W'(sum[0] / addrs.size());
                px.green = CHAN_W'(sum[1] / addrs.size());
                px.blue  = CHAN_W'(sum[2] / addrs.size());
                px.alpha = CHAN_W'(sum[3] / addrs.size());
            end else begin
                px = '{red: '0, green: '0, blue: '0, alpha: '1};
            end
            expected_px.push_back(px);
        endfunction

        function void check_sample(t_px got);
            string ch_name [N_CHAN] = '{"red", "green", "blue", "alpha"};
            t_px   exp_px;
            if (expected_px.size() == 0) begin
                errors++;
                $display("%0t: sample beat with none expected, actual %h", $time, got);
                return;
            end
            exp_px = expected_px.pop_front();
            for (int c = 0; c < N_CHAN; c++) begin
                if (got[(N_CHAN-1-c)*CHAN_W +: CHAN_W] !== exp_px[(N_CHAN-1-c)*CHAN_W +: CHAN_W]) begin
                    errors++;
                    $display("%0t: %s expected %h actual %h", $time, ch_name[c],
                             exp_px[(N_CHAN-1-c)*CHAN_W +: CHAN_W],
                             got[(N_CHAN-1-c)*CHAN_W +: CHAN_W]);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    gaps_on;
    int                    beats_sent;
    int                    quiet_cycles;
    texel_scoreboard       sb = new();

    txs_in_if  tex_if ();
    txs_out_if smp_if ();

    texture_sample_wrap_cross_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tex      (tex_if),
        .o_smp      (smp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tex_if.valid && tex_if.ready) begin
                sb.note_beat(t_in_beat'{op: tex_if.op, coord_u: tex_if.coord_u,
                                        coord_v: tex_if.coord_v,
                                        write_index: tex_if.write_index,
                                        red: tex_if.in_red, green: tex_if.in_green,
                                        blue: tex_if.in_blue, alpha: tex_if.in_alpha});
            end
            if (smp_if.valid && smp_if.ready) begin
                sb.check_sample(t_px'{red: smp_if.out_red, green: smp_if.out_green,
                                      blue: smp_if.out_blue, alpha: smp_if.out_alpha});
            end
            if ((tex_if.valid && tex_if.ready) || (smp_if.valid && smp_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("texture_sample_wrap_cross_filter_core: mismatch");
                $finish;
            end
        end
    end

    // sample sink: random stall bursts while gaps_on, long open stretches now and then
    initial begin
        smp_if.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                smp_if.ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            smp_if.ready = 1'b1;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12))
                @(negedge i_clk);
        end
    end

    task automatic send_beat(t_in_beat b);
        tex_if.valid       = 1'b1;
        tex_if.op          = b.op;
        tex_if.coord_u     = b.coord_u;
        tex_if.coord_v     = b.coord_v;
        tex_if.write_index = b.write_index;
        tex_if.in_red      = b.red;
        tex_if.in_green    = b.green;
        tex_if.in_blue     = b.blue;
        tex_if.in_alpha    = b.alpha;
        do @(posedge i_clk); while (!tex_if.ready);
        beats_sent++;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            tex_if.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic write_texel(int idx, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] bl, logic [CHAN_W-1:0] a);
        t_in_beat b;
        b.op          = OP_WRITE;
        b.coord_u     = UV_W'($urandom);
        b.coord_v     = UV_W'($urandom);
        b.write_index = WIDX_W'(idx);
        b.red         = r;
        b.green       = g;
        b.blue        = bl;
        b.alpha       = a;
        send_beat(b);
    endtask

    task automatic write_random(int idx);
        write_texel(idx, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                    CHAN_W'($urandom));
    endtask

    // every texel the lookup touches is written first
    task automatic lookup(logic signed [UV_W-1:0] u, logic signed [UV_W-1:0] v);
        int       addrs [$];
        t_in_beat b;
        sb.tap_addrs(u, v, addrs);
        foreach (addrs[k]) begin
            if (!sb.has_texel(addrs[k])) write_random(addrs[k]);
        end
        b.op          = OP_LOOKUP;
        b.coord_u     = u;
        b.coord_v     = v;
        b.write_index = WIDX_W'($urandom);
        b.red         = CHAN_W'($urandom);
        b.green       = CHAN_W'($urandom);
        b.blue        = CHAN_W'($urandom);
        b.alpha       = CHAN_W'($urandom);
        send_beat(b);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic wait_drained();
        tex_if.valid = 1'b0;
        while (sb.expected_px.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [1:0] flt, logic wrp, logic [SIZE_W-1:0] w,
                             logic [SIZE_W-1:0] h);
        logic [CFG_DATA_W-1:0] d;
        wait_drained();
        d = CFG_DATA_W'($urandom);
        d[1:0] = flt;
        write_reg(CFG_FILTER, d);
        d = CFG_DATA_W'($urandom);
        d[0] = wrp;
        write_reg(CFG_WRAP, d);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    function automatic logic signed [UV_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return UV_W'($urandom_range(0, 65535));
        if (r < 8) return UV_W'(int'($urandom_range(0, 262143)) - 131072);
        return UV_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(MAX_DIM);
            2:       return SIZE_W'($urandom_range(MAX_DIM + 1, 2047));
            3:       return SIZE_W'($urandom_range(17, MAX_DIM - 1));
            default: return SIZE_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [1:0] rand_filter();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6) return FLT_NEAREST;
        if (r < 17) return FLT_CROSS;
        if (r < 19) return FLT_BLACK;
        return FLT_BLACK_HI;
    endfunction

    task automatic random_phase(int beats);
        int     first;
        longint span;
        first = beats_sent;
        while (beats_sent - first < beats) begin
            if ($urandom_range(0, 9) < 7) begin
                lookup(rand_coord(), rand_coord());
            end else begin
                span = sb.texel_span();
                if (span <= MAX_TEXELS && $urandom_range(0, 1) == 0) begin
                    write_random(int'($urandom_range(0, int'(span) - 1)));
                end else begin
                    write_random(int'($urandom_range(0, MAX_TEXELS - 1)));
                end
            end
        end
    endtask

    initial begin
        tex_if.valid       = 1'b0;
        tex_if.op          = OP_WRITE;
        tex_if.coord_u     = '0;
        tex_if.coord_v     = '0;
        tex_if.write_index = '0;
        tex_if.in_red      = '0;
        tex_if.in_green    = '0;
        tex_if.in_blue     = '0;
        tex_if.in_alpha    = '0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        gaps_on            = 1'b1;
        beats_sent         = 0;
        quiet_cycles       = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: cross filter, repeat, 1x1 image
        write_texel(0, '1, '1, '1, '1);
        write_texel(MAX_TEXELS - 1, '0, '0, '0, '0);
        lookup(0, 0);
        lookup(UV_MIN, UV_MAX);

        // zero width and oversized height, clamped nearest fetch
        configure(FLT_NEAREST, WRAP_CLAMP, '0, '1);
        lookup(UV_MIN, UV_MIN);
        lookup(UV_MAX, UV_MAX);
        lookup(-1, 65535);

        configure(FLT_CROSS, WRAP_CLAMP, SIZE_W'(MAX_DIM), SIZE_W'(64));
        lookup(0, 0);
        lookup(UV_MAX, -1);

        configure(FLT_BLACK, WRAP_REPEAT, SIZE_W'(5), SIZE_W'(3));
        lookup(12345, -6789);
        configure(FLT_BLACK_HI, WRAP_CLAMP, SIZE_W'(5), SIZE_W'(3));
        lookup(UV_MIN, UV_MAX);

        // image larger than the store: linear address wraps
        configure(FLT_CROSS, WRAP_REPEAT, SIZE_W'(MAX_DIM), SIZE_W'(MAX_DIM));
        lookup(UV_MIN, UV_MIN);
        lookup(65535, 65535);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= RANDOM_PHASES - 2) gaps_on = 1'b0;
            configure(rand_filter(), 1'($urandom_range(0, 1)), rand_size(), rand_size());
            random_phase(PHASE_BEATS);
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("texture_sample_wrap_cross_filter_core: match");
        end else begin
            $display("texture_sample_wrap_cross_filter_core: mismatch");
        end
        $finish;
    end

endmodule
